### rtl/gnz_pkg.sv
`default_nettype none

package gnz_pkg;

    // field widths of the item and result words
    localparam int FUNC_W    = 1;
    localparam int COL_W     = 6;
    localparam int GRAD_W    = 16;
    localparam int COORD_W   = 16;
    localparam int NOISE_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] GRID_RESET     = 7'd64;

    // function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // grid size compare widths (grid limit up to 256, coordinate integer part up to 16 bits)
    localparam int DIM_W = 9;
    localparam int CMP_W = 17;

    // gradient clamp limits, Q1.14
    localparam logic signed [GRAD_W-1:0] GRAD_MAX = 16'sd16384;
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = -16'sd16384;

    // result saturation limits
    localparam int NOISE_MAX = 32767;
    localparam int NOISE_MIN = -32768;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### rtl/gnz_bank.sv
`default_nettype none

module gnz_bank #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/gnz_fifo.sv
`default_nettype none

module gnz_fifo #(
    parameter int WIDTH = 128
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output gnz_pkg::t_q_stat      o_stat
);

    import gnz_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // word storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // occupancy
    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/gnz_front.sv
`default_nettype none

module gnz_front #(
    parameter  int MAX_GRID_WIDTH  = 64,
    parameter  int MAX_GRID_HEIGHT = 64,
    parameter  int FRAC_BITS       = 10,
    localparam int WB              = (MAX_GRID_WIDTH + 1) / 2,
    localparam int HB              = (MAX_GRID_HEIGHT + 1) / 2,
    localparam int DEPTH           = WB * HB,
    localparam int BA_W            = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int ITEM_W          = 38 + 5 * BA_W + 2 * FRAC_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic        [gnz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic        [gnz_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic        [gnz_pkg::FUNC_W-1:0]      i_func,
    input  wire logic        [gnz_pkg::COL_W-1:0]       i_grid_col,
    input  wire logic        [gnz_pkg::COL_W-1:0]       i_grid_row,
    input  wire logic signed [gnz_pkg::GRAD_W-1:0]      i_grad_x,
    input  wire logic signed [gnz_pkg::GRAD_W-1:0]      i_grad_y,
    input  wire logic        [gnz_pkg::COORD_W-1:0]     i_x_coord,
    input  wire logic        [gnz_pkg::COORD_W-1:0]     i_y_coord,
    output logic             [ITEM_W-1:0]               o_item
);

    import gnz_pkg::*;

    localparam int TMP_W = COORD_W + DIM_W;

    typedef struct packed {
        logic                        is_eval;
        logic                        err;
        logic [1:0]                  wr_bank;
        logic [BA_W-1:0]             wr_addr;
        logic signed [GRAD_W-1:0]    gx;
        logic signed [GRAD_W-1:0]    gy;
        logic [3:0][BA_W-1:0]        rd_addr;
        logic [FRAC_BITS-1:0]        fx;
        logic [FRAC_BITS-1:0]        fy;
        logic                        x0p;
        logic                        y0p;
    } t_item;

    logic [CFG_DATA_W-1:0] r_grid_width;
    logic [CFG_DATA_W-1:0] r_grid_height;
    logic [DIM_W-1:0]      w_use;
    logic [DIM_W-1:0]      h_use;
    logic [COORD_W-1:0]    x0;
    logic [COORD_W-1:0]    y0;
    logic [COORD_W-1:0]    xo_h;
    logic [COORD_W-1:0]    xe_h;
    logic [COORD_W-1:0]    yo_h;
    logic [COORD_W-1:0]    ye_h;
    logic                  wr_err;
    logic                  ev_err;
    t_item                 item;

    // bank address of a corner from its halved column and row
    function automatic logic [BA_W-1:0] bank_addr(input logic [COORD_W-1:0] ch,
                                                  input logic [COORD_W-1:0] rh);
        logic [TMP_W-1:0] tmp;
        tmp = TMP_W'(ch) * TMP_W'(HB) + TMP_W'(rh);
        return tmp[BA_W-1:0];
    endfunction

    function automatic logic signed [GRAD_W-1:0] clamp_grad(input logic signed [GRAD_W-1:0] g);
        logic signed [GRAD_W-1:0] r;
        if (g > GRAD_MAX) begin
            r = GRAD_MAX;
        end else if (g < GRAD_MIN) begin
            r = GRAD_MIN;
        end else begin
            r = g;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // grid in use, limited to the table size
    assign w_use = ({2'b00, r_grid_width} > DIM_W'(MAX_GRID_WIDTH)) ?
                   DIM_W'(MAX_GRID_WIDTH) : {2'b00, r_grid_width};
    assign h_use = ({2'b00, r_grid_height} > DIM_W'(MAX_GRID_HEIGHT)) ?
                   DIM_W'(MAX_GRID_HEIGHT) : {2'b00, r_grid_height};

    // integer corner and the halved columns and rows of the four corners
    assign x0   = i_x_coord >> FRAC_BITS;
    assign y0   = i_y_coord >> FRAC_BITS;
    assign xo_h = x0 >> 1;
    assign yo_h = y0 >> 1;
    assign xe_h = (x0 >> 1) + COORD_W'(x0[0]);
    assign ye_h = (y0 >> 1) + COORD_W'(y0[0]);

    // range checks
    assign wr_err = ({3'b000, i_grid_col} >= w_use) || ({3'b000, i_grid_row} >= h_use);
    assign ev_err = (({1'b0, x0} + CMP_W'(1)) >= CMP_W'(w_use)) ||
                    (({1'b0, y0} + CMP_W'(1)) >= CMP_W'(h_use));

    // classify and build the queue word
    always_comb begin
        item.is_eval    = (i_func == FUNC_EVAL);
        item.err        = (i_func == FUNC_EVAL) ? ev_err : wr_err;
        item.wr_bank    = {i_grid_col[0], i_grid_row[0]};
        item.wr_addr    = bank_addr(COORD_W'(i_grid_col >> 1), COORD_W'(i_grid_row >> 1));
        item.gx         = clamp_grad(i_grad_x);
        item.gy         = clamp_grad(i_grad_y);
        // bank index is {column parity, row parity}
        item.rd_addr[0] = bank_addr(xe_h, ye_h);
        item.rd_addr[1] = bank_addr(xe_h, yo_h);
        item.rd_addr[2] = bank_addr(xo_h, ye_h);
        item.rd_addr[3] = bank_addr(xo_h, yo_h);
        item.fx         = i_x_coord[FRAC_BITS-1:0];
        item.fy         = i_y_coord[FRAC_BITS-1:0];
        item.x0p        = x0[0];
        item.y0p        = y0[0];
    end

    assign o_item = item;

endmodule

`default_nettype wire

### rtl/gnz_back.sv
`default_nettype none

module gnz_back #(
    parameter  int MAX_GRID_WIDTH  = 64,
    parameter  int MAX_GRID_HEIGHT = 64,
    parameter  int FRAC_BITS       = 10,
    localparam int WB              = (MAX_GRID_WIDTH + 1) / 2,
    localparam int HB              = (MAX_GRID_HEIGHT + 1) / 2,
    localparam int DEPTH           = WB * HB,
    localparam int BA_W            = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int ITEM_W          = 38 + 5 * BA_W + 2 * FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic        [ITEM_W-1:0]            i_item,
    input  gnz_pkg::t_q_stat                         i_q_stat,
    output logic                                     o_pop,
    output logic                                     o_clearing,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed      [gnz_pkg::NOISE_W-1:0]  o_noise_value,
    output logic                                     o_range_error
);

    import gnz_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int DX_W  = F + 1;
    localparam int P_W   = F + 17;
    localparam int S_W   = F + 18;
    localparam int N_W   = S_W - F;
    localparam int D1_W  = N_W + 1;
    localparam int Q1_W  = DX_W + D1_W;
    localparam int IX_W  = Q1_W - F;
    localparam int D2_W  = IX_W + 1;
    localparam int Q2_W  = DX_W + D2_W;
    localparam int R_W   = Q2_W - F;
    localparam int WORD_W = 2 * GRAD_W;

    localparam logic signed [S_W-1:0]  HALF_S  = S_W'(2 ** (F - 1));
    localparam logic signed [Q1_W-1:0] HALF_Q1 = Q1_W'(2 ** (F - 1));
    localparam logic signed [Q2_W-1:0] HALF_Q2 = Q2_W'(2 ** (F - 1));
    localparam logic signed [R_W-1:0]  SAT_HI  = R_W'(NOISE_MAX);
    localparam logic signed [R_W-1:0]  SAT_LO  = R_W'(NOISE_MIN);

    typedef struct packed {
        logic                        is_eval;
        logic                        err;
        logic [1:0]                  wr_bank;
        logic [BA_W-1:0]             wr_addr;
        logic signed [GRAD_W-1:0]    gx;
        logic signed [GRAD_W-1:0]    gy;
        logic [3:0][BA_W-1:0]        rd_addr;
        logic [FRAC_BITS-1:0]        fx;
        logic [FRAC_BITS-1:0]        fy;
        logic                        x0p;
        logic                        y0p;
    } t_item;

    t_item             item;
    logic              adv;
    logic              pop;
    logic              r_clr_busy;
    logic [BA_W-1:0]   r_clr_addr;
    logic [WORD_W-1:0] rd_data [4];

    // stage 1: bank read data
    logic              r_v1, r_ev1, r_err1, r_x0p1, r_y0p1;
    logic [F-1:0]      r_fx1, r_fy1;
    // stage 2: corner products
    logic              r_v2, r_ev2, r_err2;
    logic [F-1:0]      r_fx2, r_fy2;
    logic signed [P_W-1:0] r_px [4];
    logic signed [P_W-1:0] r_py [4];
    logic signed [P_W-1:0] n_px [4];
    logic signed [P_W-1:0] n_py [4];
    // stage 3: corner dot products
    logic              r_v3, r_ev3, r_err3;
    logic [F-1:0]      r_fx3, r_fy3;
    logic signed [N_W-1:0] r_n [4];
    logic signed [N_W-1:0] n_n [4];
    logic signed [S_W-1:0] s_sum [4];
    // stage 4: x interpolation products
    logic              r_v4, r_ev4, r_err4;
    logic [F-1:0]      r_fy4;
    logic signed [N_W-1:0]  r_a0, r_a1;
    logic signed [Q1_W-1:0] r_q0, r_q1;
    logic signed [D1_W-1:0] d0, d1;
    logic signed [DX_W-1:0] tx;
    // stage 5: x interpolation results
    logic              r_v5, r_ev5, r_err5;
    logic [F-1:0]      r_fy5;
    logic signed [IX_W-1:0] r_ix0, r_ix1;
    logic signed [Q1_W-1:0] q0_rnd, q1_rnd;
    logic signed [IX_W-1:0] ix0, ix1;
    // stage 6: y interpolation product
    logic              r_v6, r_ev6, r_err6;
    logic signed [IX_W-1:0] r_a2;
    logic signed [Q2_W-1:0] r_q2;
    logic signed [D2_W-1:0] d2;
    logic signed [DX_W-1:0] ty;
    // stage 7: output register
    logic              r_v7, r_err7;
    logic signed [NOISE_W-1:0] r_noise;
    logic signed [Q2_W-1:0] q2_rnd;
    logic signed [R_W-1:0]  res;
    logic signed [R_W-1:0]  res_sat;

    assign item = i_item;

    // whole pipeline moves while the output register is free or taken
    assign adv        = !r_v7 || i_ready;
    assign pop        = adv && !i_q_stat.empty && !r_clr_busy;
    assign o_pop      = pop;
    assign o_clearing = r_clr_busy;

    // clearing pass over the banks after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == BA_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + BA_W'(1);
            end
        end
    end

    // four gradient banks interleaved by column and row parity
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic              bank_we;
        logic [BA_W-1:0]   bank_waddr;
        logic [WORD_W-1:0] bank_wdata;

        assign bank_we    = r_clr_busy ||
                            (pop && !item.is_eval && !item.err && (item.wr_bank == 2'(b)));
        assign bank_waddr = r_clr_busy ? r_clr_addr : item.wr_addr;
        assign bank_wdata = r_clr_busy ? '0 : {item.gx, item.gy};

        gnz_bank #(
            .DEPTH (DEPTH),
            .AW    (BA_W),
            .DW    (WORD_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we),
            .i_waddr (bank_waddr),
            .i_wdata (bank_wdata),
            .i_re    (pop),
            .i_raddr (item.rd_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (adv) begin
            r_v1 <= pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // corner products, corners ordered (x0,y0) (x0+1,y0) (x0,y0+1) (x0+1,y0+1)
    always_comb begin
        logic [1:0]             cidx;
        logic signed [DX_W-1:0] dxs;
        logic signed [DX_W-1:0] dys;
        logic signed [GRAD_W-1:0] gxs;
        logic signed [GRAD_W-1:0] gys;
        for (int k = 0; k < 4; k++) begin
            cidx  = {r_x0p1 ^ k[0], r_y0p1 ^ k[1]};
            gxs   = rd_data[cidx][WORD_W-1:GRAD_W];
            gys   = rd_data[cidx][GRAD_W-1:0];
            // offset to the far corner is frac - one, which is {1, frac}
            dxs   = k[0] ? {1'b1, r_fx1} : {1'b0, r_fx1};
            dys   = k[1] ? {1'b1, r_fy1} : {1'b0, r_fy1};
            n_px[k] = dxs * gxs;
            n_py[k] = dys * gys;
        end
    end

    // dot products rounded to Q14
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            s_sum[k] = S_W'(r_px[k]) + S_W'(r_py[k]) + HALF_S;
            n_n[k]   = s_sum[k][S_W-1:F];
        end
    end

    // x interpolation products
    assign tx = {1'b0, r_fx3};
    assign d0 = D1_W'(r_n[1]) - D1_W'(r_n[0]);
    assign d1 = D1_W'(r_n[3]) - D1_W'(r_n[2]);

    // x interpolation results
    assign q0_rnd = r_q0 + HALF_Q1;
    assign q1_rnd = r_q1 + HALF_Q1;
    assign ix0    = IX_W'(r_a0) + $signed(q0_rnd[Q1_W-1:F]);
    assign ix1    = IX_W'(r_a1) + $signed(q1_rnd[Q1_W-1:F]);

    // y interpolation product
    assign ty = {1'b0, r_fy5};
    assign d2 = D2_W'(r_ix1) - D2_W'(r_ix0);

    // y interpolation result and saturation
    assign q2_rnd = r_q2 + HALF_Q2;
    assign res    = R_W'(r_a2) + $signed(q2_rnd[Q2_W-1:F]);

    always_comb begin
        priority if (res > SAT_HI) begin
            res_sat = SAT_HI;
        end else if (res < SAT_LO) begin
            res_sat = SAT_LO;
        end else begin
            res_sat = res;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ev1  <= item.is_eval && !item.err;
            r_err1 <= item.err;
            r_fx1  <= item.fx;
            r_fy1  <= item.fy;
            r_x0p1 <= item.x0p;
            r_y0p1 <= item.y0p;

            r_ev2  <= r_ev1;
            r_err2 <= r_err1;
            r_fx2  <= r_fx1;
            r_fy2  <= r_fy1;
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= n_px[k];
                r_py[k] <= n_py[k];
            end

            r_ev3  <= r_ev2;
            r_err3 <= r_err2;
            r_fx3  <= r_fx2;
            r_fy3  <= r_fy2;
            for (int k = 0; k < 4; k++) begin
                r_n[k] <= n_n[k];
            end

            r_ev4  <= r_ev3;
            r_err4 <= r_err3;
            r_fy4  <= r_fy3;
            r_a0   <= r_n[0];
            r_a1   <= r_n[2];
            r_q0   <= tx * d0;
            r_q1   <= tx * d1;

            r_ev5  <= r_ev4;
            r_err5 <= r_err4;
            r_fy5  <= r_fy4;
            r_ix0  <= ix0;
            r_ix1  <= ix1;

            r_ev6  <= r_ev5;
            r_err6 <= r_err5;
            r_a2   <= r_ix0;
            r_q2   <= ty * d2;

            r_err7  <= r_err6;
            r_noise <= r_ev6 ? res_sat[NOISE_W-1:0] : '0;
        end
    end

    assign o_valid       = r_v7;
    assign o_noise_value = r_noise;
    assign o_range_error = r_err7;

endmodule

`default_nettype wire

### rtl/gradient_noise_2d.sv
`default_nettype none

// Two-dimensional gradient noise over a loadable grid of Q1.14 gradient vectors.
// Each input word either writes one gradient (clamped to +/-1.0) or evaluates
// bilinear gradient noise at an unsigned fixed-point point, and gives exactly one
// result word: a Q1.14 value and a range error flag. Words are taken one per
// cycle while the queue has room and the store is not clearing, and results
// leave one per cycle while the output is not stalled, in order; a four-word
// queue between the classifying front end and the arithmetic pipeline lets
// input keep flowing while the output is stalled, until the queue fills. The
// rate is set by the gradient store, split into four banks by column and row
// parity so the four corners of a point are read in the same cycle, one read
// port each. After reset the store is cleared one bank row per cycle, across
// ((MAX_GRID_WIDTH+1)/2) * ((MAX_GRID_HEIGHT+1)/2) rows (1024 at the default
// size); no input word is accepted during that pass, configuration writes are.
// Grid width and height may be changed only while the block is idle.
module gradient_noise_2d #(
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64,
    parameter int FRAC_BITS       = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_we,
    input  wire logic        [gnz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic        [gnz_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic        [gnz_pkg::FUNC_W-1:0]      i_func,
    input  wire logic        [gnz_pkg::COL_W-1:0]       i_grid_col,
    input  wire logic        [gnz_pkg::COL_W-1:0]       i_grid_row,
    input  wire logic signed [gnz_pkg::GRAD_W-1:0]      i_grad_x,
    input  wire logic signed [gnz_pkg::GRAD_W-1:0]      i_grad_y,
    input  wire logic        [gnz_pkg::COORD_W-1:0]     i_x_coord,
    input  wire logic        [gnz_pkg::COORD_W-1:0]     i_y_coord,
    // output channel
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed      [gnz_pkg::NOISE_W-1:0]     o_noise_value,
    output logic                                        o_range_error
);

    import gnz_pkg::*;

    localparam int WB     = (MAX_GRID_WIDTH + 1) / 2;
    localparam int HB     = (MAX_GRID_HEIGHT + 1) / 2;
    localparam int DEPTH  = WB * HB;
    localparam int BA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ITEM_W = 38 + 5 * BA_W + 2 * FRAC_BITS;

    logic [ITEM_W-1:0] front_item;
    logic [ITEM_W-1:0] queue_item;
    t_q_stat           q_stat;
    logic              q_pop;
    logic              clearing;
    logic              push;

    // input words enter the queue unless it is full or the store is clearing
    assign o_ready = !q_stat.full && !clearing;
    assign push    = i_valid && o_ready;

    gnz_front #(
        .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
        .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
        .FRAC_BITS       (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_grid_col  (i_grid_col),
        .i_grid_row  (i_grid_row),
        .i_grad_x    (i_grad_x),
        .i_grad_y    (i_grad_y),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .o_item      (front_item)
    );

    gnz_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (queue_item),
        .o_stat  (q_stat)
    );

    gnz_back #(
        .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
        .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (queue_item),
        .i_q_stat      (q_stat),
        .o_pop         (q_pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_noise_value (o_noise_value),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gnz_pkg::*;

    localparam int MAX_W           = 64;
    localparam int MAX_H           = 64;
    localparam int FRAC            = 10;
    localparam int FRAC_MASK       = (1 << FRAC) - 1;
    localparam longint ONE         = longint'(1) << FRAC;
    localparam longint HALF        = ONE >>> 1;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 16;
    localparam int IDLE_LIMIT      = 4000;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 140;
    localparam int DIR_ROWS        = 26;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic signed [NOISE_W-1:0] noise;
        logic                      err;
    } t_noise_res;

    typedef struct {
        bit [CFG_DATA_W-1:0]      w;
        bit [CFG_DATA_W-1:0]      h;
        logic                     func;
        logic [COL_W-1:0]         col;
        logic [COL_W-1:0]         row;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COORD_W-1:0]       xc;
        logic [COORD_W-1:0]       yc;
        bit                       typed;
        logic signed [NOISE_W-1:0] noise;
        logic                     err;
    } t_dir_row;

    // dut connections
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [FUNC_W-1:0]         in_func = '0;
    logic [COL_W-1:0]          in_col = '0;
    logic [COL_W-1:0]          in_row = '0;
    logic signed [GRAD_W-1:0]  in_grad_x = '0;
    logic signed [GRAD_W-1:0]  in_grad_y = '0;
    logic [COORD_W-1:0]        in_x = '0;
    logic [COORD_W-1:0]        in_y = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [NOISE_W-1:0] noise_value;
    logic                      range_error;

    // shadow gradient store and grid size
    logic signed [GRAD_W-1:0] grad_x_tab [MAX_W*MAX_H];
    logic signed [GRAD_W-1:0] grad_y_tab [MAX_W*MAX_H];
    bit [CFG_DATA_W-1:0]      grid_w_cfg = GRID_RESET;
    bit [CFG_DATA_W-1:0]      grid_h_cfg = GRID_RESET;

    t_noise_res noise_expected_q [$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    t_dir_row   dir_tab [DIR_ROWS];

    gradient_noise_2d #(
        .MAX_GRID_WIDTH (MAX_W),
        .MAX_GRID_HEIGHT(MAX_H),
        .FRAC_BITS      (FRAC)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_func       (in_func),
        .i_grid_col   (in_col),
        .i_grid_row   (in_row),
        .i_grad_x     (in_grad_x),
        .i_grad_y     (in_grad_y),
        .i_x_coord    (in_x),
        .i_y_coord    (in_y),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_noise_value(noise_value),
        .o_range_error(range_error)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // grid size actually used by the block
    function automatic int unsigned in_use(bit [CFG_DATA_W-1:0] v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // floor((v + half) / 2^frac)
    function automatic longint round_q(longint v);
        return (v + HALF) >>> FRAC;
    endfunction

    function automatic longint corner_dot(int unsigned col, int unsigned row,
                                          longint dx, longint dy);
        int unsigned idx;
        idx = col * MAX_H + row;
        return round_q(dx * grad_x_tab[idx] + dy * grad_y_tab[idx]);
    endfunction

    function automatic longint lerp_q(longint a, longint b, longint t);
        return a + round_q(t * (b - a));
    endfunction

    function automatic logic signed [GRAD_W-1:0] clamp_grad(logic signed [GRAD_W-1:0] g);
        if (g > GRAD_MAX)
            return GRAD_MAX;
        if (g < GRAD_MIN)
            return GRAD_MIN;
        return g;
    endfunction

    // expected result of one word, updates the shadow store on writes
    function automatic t_noise_res predict_noise(
        logic fn, logic [COL_W-1:0] col, logic [COL_W-1:0] row,
        logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
        logic [COORD_W-1:0] xc, logic [COORD_W-1:0] yc);
        int unsigned wu, hu, x0, y0, idx;
        longint      fx, fy, n0, n1, ix0, ix1, acc;
        t_noise_res  res;
        res = '0;
        wu = in_use(grid_w_cfg, MAX_W);
        hu = in_use(grid_h_cfg, MAX_H);
        if (fn == FUNC_WRITE) begin
            if (col >= wu || row >= hu) begin
                res.err = 1'b1;
            end else begin
                idx = col * MAX_H + row;
                grad_x_tab[idx] = clamp_grad(gx);
                grad_y_tab[idx] = clamp_grad(gy);
            end
            return res;
        end
        x0 = xc >> FRAC;
        y0 = yc >> FRAC;
        fx = longint'(xc & FRAC_MASK);
        fy = longint'(yc & FRAC_MASK);
        if (x0 + 1 >= wu || y0 + 1 >= hu) begin
            res.err = 1'b1;
            return res;
        end
        // interpolate along x on both rows, then along y
        n0  = corner_dot(x0, y0, fx, fy);
        n1  = corner_dot(x0 + 1, y0, fx - ONE, fy);
        ix0 = lerp_q(n0, n1, fx);
        n0  = corner_dot(x0, y0 + 1, fx, fy - ONE);
        n1  = corner_dot(x0 + 1, y0 + 1, fx - ONE, fy - ONE);
        ix1 = lerp_q(n0, n1, fx);
        acc = lerp_q(ix0, ix1, fy);
        if (acc > NOISE_MAX)
            acc = NOISE_MAX;
        if (acc < NOISE_MIN)
            acc = NOISE_MIN;
        res.noise = acc[NOISE_W-1:0];
        return res;
    endfunction

    // mostly legal gradients, some extremes and some beyond one
    function automatic logic signed [GRAD_W-1:0] rand_grad();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return GRAD_W'($urandom_range(65535));
        if (pick == 1)
            return ($urandom_range(1) != 0) ? GRAD_MAX : GRAD_MIN;
        return GRAD_W'(int'($urandom_range(32768)) - 16384);
    endfunction

    // offer one word and record its expected result on acceptance
    task automatic send_word(input logic fn, input logic [COL_W-1:0] col,
                             input logic [COL_W-1:0] row,
                             input logic signed [GRAD_W-1:0] gx,
                             input logic signed [GRAD_W-1:0] gy,
                             input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc,
                             input bit typed, input t_noise_res typed_res);
        t_noise_res res;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_func   <= fn;
        in_col    <= col;
        in_row    <= row;
        in_grad_x <= gx;
        in_grad_y <= gy;
        in_x      <= xc;
        in_y      <= yc;
        do begin
            @(posedge clk);
        end while (!(in_valid && in_ready));
        res = predict_noise(fn, col, row, gx, gy, xc, yc);
        noise_expected_q.push_back(typed ? typed_res : res);
    endtask

    // change grid size once the pipeline has drained
    task automatic program_grid(input bit [CFG_DATA_W-1:0] w, input bit [CFG_DATA_W-1:0] h);
        in_valid <= 1'b0;
        while (noise_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        grid_w_cfg = w;
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        grid_h_cfg = h;
        // unused index, must be ignored
        cfg_index <= ($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data  <= CFG_DATA_W'($urandom_range(127));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random result backpressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker and watchdog
    always @(posedge clk) begin : check_results
        t_noise_res exp_res;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            if (noise_expected_q.size() == 0) begin
                $display("%0t: unexpected word noise=%0d err=%0b", $time,
                         noise_value, range_error);
                mismatch_count++;
            end else begin
                exp_res = noise_expected_q.pop_front();
                if (noise_value !== exp_res.noise) begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             exp_res.noise, noise_value);
                    mismatch_count++;
                end
                if (range_error !== exp_res.err) begin
                    $display("%0t: range_error expected %0b actual %0b", $time,
                             exp_res.err, range_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int                       i, ph, n, kind;
        int unsigned              wu, hu;
        logic                     f;
        logic [COL_W-1:0]         c, r;
        logic signed [GRAD_W-1:0] gx, gy;
        logic [COORD_W-1:0]       xc, yc;
        bit [CFG_DATA_W-1:0]      w, h;
        t_noise_res               tres;

        for (i = 0; i < MAX_W * MAX_H; i++) begin
            grad_x_tab[i] = '0;
            grad_y_tab[i] = '0;
        end

        // w, h, func, col, row, gx, gy, x, y, typed, noise, err
        // cleared store gives zero, corners past the grid edge flag an error
        dir_tab[0]  = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 0, 0, 1, 0, 0};
        dir_tab[1]  = '{64, 64, FUNC_EVAL, 63, 63, 32767, -32768, 64511, 64511, 1, 0, 0};
        dir_tab[2]  = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 64512, 0, 1, 0, 1};
        dir_tab[3]  = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 0, 65535, 1, 0, 1};
        // gradients pointing at the cell center, last one clamped
        dir_tab[4]  = '{64, 64, FUNC_WRITE, 0, 0, 16384, 16384, 0, 0, 1, 0, 0};
        dir_tab[5]  = '{64, 64, FUNC_WRITE, 1, 0, -16384, 16384, 0, 0, 1, 0, 0};
        dir_tab[6]  = '{64, 64, FUNC_WRITE, 0, 1, 16384, -16384, 0, 0, 1, 0, 0};
        dir_tab[7]  = '{64, 64, FUNC_WRITE, 1, 1, -20000, -32768, 0, 0, 1, 0, 0};
        dir_tab[8]  = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 512, 512, 1, 16384, 0};
        dir_tab[9]  = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 100, 900, 0, 0, 0};
        dir_tab[10] = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 1023, 1, 0, 0, 0};
        // far corner of the full grid
        dir_tab[11] = '{64, 64, FUNC_WRITE, 63, 63, 32767, -1, 0, 0, 1, 0, 0};
        dir_tab[12] = '{64, 64, FUNC_WRITE, 62, 62, -1, 16385, 0, 0, 1, 0, 0};
        dir_tab[13] = '{64, 64, FUNC_WRITE, 62, 63, 12345, -23456, 0, 0, 1, 0, 0};
        dir_tab[14] = '{64, 64, FUNC_EVAL, 0, 0, 0, 0, 64511, 64511, 0, 0, 0};
        // small grid, writes and points on and past the edge
        dir_tab[15] = '{4, 3, FUNC_WRITE, 3, 2, 5000, -7000, 0, 0, 1, 0, 0};
        dir_tab[16] = '{4, 3, FUNC_WRITE, 4, 0, 100, 100, 0, 0, 1, 0, 1};
        dir_tab[17] = '{4, 3, FUNC_WRITE, 0, 3, 100, 100, 0, 0, 1, 0, 1};
        dir_tab[18] = '{4, 3, FUNC_EVAL, 0, 0, 0, 0, 3071, 2047, 0, 0, 0};
        dir_tab[19] = '{4, 3, FUNC_EVAL, 0, 0, 0, 0, 3072, 0, 1, 0, 1};
        dir_tab[20] = '{4, 3, FUNC_EVAL, 0, 0, 0, 0, 0, 2048, 1, 0, 1};
        // grid below two cells
        dir_tab[21] = '{1, 64, FUNC_EVAL, 0, 0, 0, 0, 0, 0, 1, 0, 1};
        dir_tab[22] = '{0, 0, FUNC_WRITE, 0, 0, 100, 100, 0, 0, 1, 0, 1};
        // oversized setting acts as the full grid
        dir_tab[23] = '{127, 127, FUNC_EVAL, 0, 0, 0, 0, 64511, 64511, 0, 0, 0};
        dir_tab[24] = '{127, 127, FUNC_WRITE, 63, 0, -16384, -16384, 0, 0, 1, 0, 0};
        dir_tab[25] = '{2, 2, FUNC_EVAL, 0, 0, 0, 0, 1023, 1023, 0, 0, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed words
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].w != grid_w_cfg || dir_tab[i].h != grid_h_cfg)
                program_grid(dir_tab[i].w, dir_tab[i].h);
            tres.noise = dir_tab[i].noise;
            tres.err   = dir_tab[i].err;
            send_word(dir_tab[i].func, dir_tab[i].col, dir_tab[i].row, dir_tab[i].gx,
                      dir_tab[i].gy, dir_tab[i].xc, dir_tab[i].yc, dir_tab[i].typed, tres);
        end

        // random phases over grid sizes and idle patterns
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin w = 64; h = 64; end
                1: begin w = 2; h = 2; end
                2: begin w = 127; h = 127; end
                4: begin w = 17; h = 5; end
                5: begin w = 64; h = 2; end
                6: begin w = 2; h = 64; end
                7: begin w = 1; h = 40; end
                8: begin
                    w = CFG_DATA_W'($urandom_range(127));
                    h = CFG_DATA_W'($urandom_range(127));
                end
                default: begin
                    w = CFG_DATA_W'($urandom_range(64, 2));
                    h = CFG_DATA_W'($urandom_range(64, 2));
                end
            endcase
            program_grid(w, h);
            case (ph % 4)
                0: begin gap_pct = 0; stall_pct = 0; end
                1: begin gap_pct = 58; stall_pct = 0; end
                2: begin gap_pct = 0; stall_pct = 58; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            wu = in_use(grid_w_cfg, MAX_W);
            hu = in_use(grid_h_cfg, MAX_H);
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                // unused fields carry random bits too
                c    = COL_W'($urandom_range(63));
                r    = COL_W'($urandom_range(63));
                gx   = GRAD_W'($urandom_range(65535));
                gy   = GRAD_W'($urandom_range(65535));
                xc   = COORD_W'($urandom_range(65535));
                yc   = COORD_W'($urandom_range(65535));
                kind = $urandom_range(99);
                if (kind < 35) begin
                    f = FUNC_WRITE;
                    if (wu > 0 && $urandom_range(9) != 0)
                        c = COL_W'($urandom_range(wu - 1));
                    if (hu > 0 && $urandom_range(9) != 0)
                        r = COL_W'($urandom_range(hu - 1));
                    gx = rand_grad();
                    gy = rand_grad();
                end else begin
                    f = FUNC_EVAL;
                    // mostly points whose four corners lie inside the grid
                    if (wu >= 2 && hu >= 2 && $urandom_range(9) != 0) begin
                        xc = COORD_W'(($urandom_range(wu - 2) << FRAC) |
                                      $urandom_range(FRAC_MASK));
                        yc = COORD_W'(($urandom_range(hu - 2) << FRAC) |
                                      $urandom_range(FRAC_MASK));
                    end
                end
                send_word(f, c, r, gx, gy, xc, yc, 1'b0, '0);
            end
        end

        // drain and finish
        in_valid  <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        while (noise_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/gnz_pkg.sv
rtl/gnz_bank.sv
rtl/gnz_fifo.sv
rtl/gnz_front.sv
rtl/gnz_back.sv
rtl/gradient_noise_2d.sv
tb/sv/testbench.sv
